// ===== design/cbq_pkg.sv =====
// Package for the cascaded biquad filter: widths, register and state codes,
// MAC control struct and saturation limits. No dependencies.
package cbq_pkg;

    localparam int MAX_STAGES    = 5;
    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 32;
    localparam int COEF_FRAC     = COEF_BITS - 5;
    localparam int PROD_BITS     = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS      = 64;
    localparam int SEC_BITS      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_BITS      = $clog2(MAX_STAGES + 1);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COEF_BITS;
    localparam int STAGE_CNT_BITS = 3;

    localparam logic [STAGE_CNT_BITS-1:0] STAGE_COUNT_RESET = 3'd2;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(64'sd1 <<< COEF_FRAC);

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(64'sd1 <<< (COEF_FRAC - 1));

    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BYPASS      = 3'd0,
        REG_STAGE_COUNT = 3'd1,
        REG_COEF_B0     = 3'd2,
        REG_COEF_B1     = 3'd3,
        REG_COEF_B2     = 3'd4,
        REG_COEF_A1     = 3'd5,
        REG_COEF_A2     = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        TERM_B0,
        TERM_B1,
        TERM_B2,
        TERM_A1,
        TERM_A2
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic vld;    // issue a product this cycle
        logic first;  // product starts a fresh accumulation
        logic sub;    // feedback term, subtracted
    } mac_ctl_t;

endpackage

// ===== design/cbq_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on cbq_pkg.
module cbq_mac
    import cbq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mac_ctl_t                    ctl,
    input  logic signed [COEF_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0] samp,
    output logic signed [ACC_BITS-1:0]  acc
);

    logic signed [PROD_BITS-1:0] prod_reg;
    mac_ctl_t                    ctl_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_base;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            prod_reg <= coef * samp;
        end
        if (ctl_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        acc_base = ctl_reg.first ? '0 : acc_reg;
        prod_ext = ACC_BITS'(prod_reg);
        acc_next = ctl_reg.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end

    assign acc = acc_reg;

endmodule

// ===== design/cascaded_biquad_df1_filter_top.sv =====
// A sample is worked through the n active sections; bypass or n = 0 skips them all.
// A new sample is taken only after the previous result is loaded into the output register.
// Each section issues five products through the one shared MAC unit, then drains
// the accumulator (ST_WAIT) and rounds and saturates the section result (ST_ROUND).
// Reset: registers to defaults (b0 = 1.0, two sections), delay lines zero.
// Top level of the cascaded biquad filter; depends on cbq_pkg and cbq_mac.
module cascaded_biquad_df1_filter_top
    import cbq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    state_t state_reg, state_next;
    term_t  term_reg, term_next;
    logic [SEC_BITS-1:0] sec_reg;

    logic                          bypass_reg;
    logic [STAGE_CNT_BITS-1:0]     stage_count_reg;
    logic signed [COEF_BITS-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    logic signed [SAMPLE_BITS-1:0] x1_reg [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] x2_reg [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] y1_reg [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] y2_reg [MAX_STAGES];

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          out_valid_reg;

    logic [CNT_BITS-1:0]           n_eff;
    logic                          last_sec;
    logic                          in_xfer;
    logic                          cfg_xfer;
    logic                          out_load;

    mac_ctl_t                      mac_ctl;
    logic signed [COEF_BITS-1:0]   mac_coef;
    logic signed [SAMPLE_BITS-1:0] mac_samp;
    logic signed [ACC_BITS-1:0]    mac_acc;

    logic signed [ACC_BITS-1:0]    rnd_sum;
    logic signed [ACC_BITS-1:0]    rnd_q;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        if (32'(stage_count_reg) > MAX_STAGES)
            n_eff = CNT_BITS'(MAX_STAGES);
        else
            n_eff = CNT_BITS'(stage_count_reg);
        last_sec = ((CNT_BITS'(sec_reg) + CNT_BITS'(1)) == n_eff);
    end

    // operand select for the shared MAC
    always_comb
    begin
        mac_coef = b0_reg;
        mac_samp = x_reg;
        case (term_reg)
            TERM_B0:
            begin
                mac_coef = b0_reg;
                mac_samp = x_reg;
            end
            TERM_B1:
            begin
                mac_coef = b1_reg;
                mac_samp = x1_reg[sec_reg];
            end
            TERM_B2:
            begin
                mac_coef = b2_reg;
                mac_samp = x2_reg[sec_reg];
            end
            TERM_A1:
            begin
                mac_coef = a1_reg;
                mac_samp = y1_reg[sec_reg];
            end
            TERM_A2:
            begin
                mac_coef = a2_reg;
                mac_samp = y2_reg[sec_reg];
            end
            default:
            begin
                mac_coef = b0_reg;
                mac_samp = x_reg;
            end
        endcase
    end

    cbq_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .coef  (mac_coef),
        .samp  (mac_samp),
        .acc   (mac_acc)
    );

    // round half up, then clamp to the sample range
    always_comb
    begin
        rnd_sum = mac_acc + ROUND_HALF;
        rnd_q   = rnd_sum >>> COEF_FRAC;
        if (rnd_q > SAT_HI)
            sat_val = SAMPLE_BITS'(SAT_HI);
        else if (rnd_q < SAT_LO)
            sat_val = SAMPLE_BITS'(SAT_LO);
        else
            sat_val = SAMPLE_BITS'(rnd_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_B0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        mac_ctl    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                term_next = TERM_B0;
                if (in_valid)
                begin
                    if (bypass_reg || (n_eff == '0))
                        state_next = ST_DONE;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mac_ctl.vld   = 1'b1;
                mac_ctl.first = (term_reg == TERM_B0);
                mac_ctl.sub   = (term_reg == TERM_A1) || (term_reg == TERM_A2);
                unique case (term_reg)
                    TERM_B0: term_next = TERM_B1;
                    TERM_B1: term_next = TERM_B2;
                    TERM_B2: term_next = TERM_A1;
                    TERM_A1: term_next = TERM_A2;
                    default:
                    begin
                        term_next  = TERM_B0;
                        state_next = ST_WAIT;
                    end
                endcase
            end
            ST_WAIT:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                term_next  = TERM_B0;
                state_next = last_sec ? ST_DONE : ST_MUL;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // config registers and delay lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg      <= 1'b0;
            stage_count_reg <= STAGE_COUNT_RESET;
            b0_reg          <= COEF_ONE;
            b1_reg          <= '0;
            b2_reg          <= '0;
            a1_reg          <= '0;
            a2_reg          <= '0;
            for (int k = 0; k < MAX_STAGES; k++)
            begin
                x1_reg[k] <= '0;
                x2_reg[k] <= '0;
                y1_reg[k] <= '0;
                y2_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_xfer)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_BYPASS:      bypass_reg <= cfg_data[0];
                    REG_STAGE_COUNT:
                    begin
                        stage_count_reg <= cfg_data[STAGE_CNT_BITS-1:0];
                        for (int k = 0; k < MAX_STAGES; k++)
                        begin
                            x1_reg[k] <= '0;
                            x2_reg[k] <= '0;
                            y1_reg[k] <= '0;
                            y2_reg[k] <= '0;
                        end
                    end
                    REG_COEF_B0:     b0_reg <= COEF_BITS'(cfg_data);
                    REG_COEF_B1:     b1_reg <= COEF_BITS'(cfg_data);
                    REG_COEF_B2:     b2_reg <= COEF_BITS'(cfg_data);
                    REG_COEF_A1:     a1_reg <= COEF_BITS'(cfg_data);
                    REG_COEF_A2:     a2_reg <= COEF_BITS'(cfg_data);
                    default:         ;
                endcase
            end
            else if (state_reg == ST_ROUND)
            begin
                x2_reg[sec_reg] <= x1_reg[sec_reg];
                x1_reg[sec_reg] <= x_reg;
                y2_reg[sec_reg] <= y1_reg[sec_reg];
                y1_reg[sec_reg] <= sat_val;
            end
        end
    end

    // datapath: section input, section index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg <= '0;
        end
        else if (in_xfer)
        begin
            sec_reg <= '0;
        end
        else if ((state_reg == ST_ROUND) && !last_sec)
        begin
            sec_reg <= sec_reg + SEC_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            x_reg <= sample_in;
        else if (state_reg == ST_ROUND)
            x_reg <= sat_val;
        if (out_load)
            out_reg <= x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // a new sample is never taken while one is in work
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken twice in a row");

    // bypass or zero sections skip the MAC entirely
    a_bypass_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (bypass_reg || (n_eff == '0))) |=> (state_reg == ST_DONE))
        else $error("bypass did not skip the sections");

    // section index stays within the active section count while rounding
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (CNT_BITS'(sec_reg) < n_eff))
        else $error("section index out of range");

    // an accumulation always starts with the b0 product
    a_mac_first: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_ctl.vld && $past(state_reg) != ST_MUL) |-> mac_ctl.first)
        else $error("accumulation not restarted at section start");

endmodule

// ===== tb/sv/biquad_response_check.sv =====
// Checker for the cascaded biquad filter: watches the config, sample-in and
// sample-out channels, predicts each filtered sample and compares in order.
// Depends on cbq_pkg.
`timescale 1ns / 1ps

module biquad_response_check
    import cbq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    output int                            mismatch_count,
    output int                            samples_in_flight
);

    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (COEF_FRAC - 1);

    // register copies
    logic                        bypass_on;
    logic [STAGE_CNT_BITS-1:0]   stage_limit;
    logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2;

    // per-section delay lines
    logic signed [SAMPLE_BITS-1:0] hist_x1 [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] hist_x2 [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] hist_y1 [MAX_STAGES];
    logic signed [SAMPLE_BITS-1:0] hist_y2 [MAX_STAGES];

    logic signed [SAMPLE_BITS-1:0] expected_samples [$];
    int                            fail_tally;

    task automatic clear_history();
        for (int k = 0; k < MAX_STAGES; k++)
        begin
            hist_x1[k] = '0;
            hist_x2[k] = '0;
            hist_y1[k] = '0;
            hist_y2[k] = '0;
        end
    endtask

    task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_BYPASS:      bypass_on = data[0];
            REG_STAGE_COUNT:
            begin
                stage_limit = data[STAGE_CNT_BITS-1:0];
                clear_history();
            end
            REG_COEF_B0:     b0 = data;
            REG_COEF_B1:     b1 = data;
            REG_COEF_B2:     b2 = data;
            REG_COEF_A1:     a1 = data;
            REG_COEF_A2:     a2 = data;
            default:         ;  // unmapped index, dropped
        endcase
    endtask

    // Runs one sample through the active sections and updates the delay lines.
    function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
        input logic signed [SAMPLE_BITS-1:0] x_in);
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [63:0]            acc;
        int                            n;
        s = x_in;
        n = (stage_limit > MAX_STAGES) ? MAX_STAGES : int'(stage_limit);
        if (!bypass_on)
        begin
            for (int k = 0; k < n; k++)
            begin
                // 64-bit context: every product is exact at these widths
                acc = b0 * s + b1 * hist_x1[k] + b2 * hist_x2[k]
                    - a1 * hist_y1[k] - a2 * hist_y2[k];
                acc = (acc + HALF_LSB) >>> COEF_FRAC;
                if (acc > OUT_MAX)
                    acc = OUT_MAX;
                else if (acc < OUT_MIN)
                    acc = OUT_MIN;
                hist_x2[k] = hist_x1[k];
                hist_x1[k] = s;
                hist_y2[k] = hist_y1[k];
                hist_y1[k] = acc[SAMPLE_BITS-1:0];
                s = acc[SAMPLE_BITS-1:0];
            end
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SAMPLE_BITS-1:0] want;
        if (!rst_n)
        begin
            bypass_on   = 1'b0;
            stage_limit = STAGE_COUNT_RESET;
            b0          = COEF_ONE;
            b1          = '0;
            b2          = '0;
            a1          = '0;
            a2          = '0;
            clear_history();
            expected_samples.delete();
            fail_tally = 0;
            mismatch_count    <= 0;
            samples_in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            // pop before push: a result never belongs to the sample taken on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample_out transfer with nothing expected: actual %0d", sample_out);
                    fail_tally++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want, sample_out);
                        fail_tally++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_samples.push_back(filter_sample(sample_in));
            mismatch_count    <= fail_tally;
            samples_in_flight <= expected_samples.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the cascaded biquad filter testbench: clock, reset, stimulus with
// random gaps and back-pressure, watchdog and verdict.
// Depends on cbq_pkg, cascaded_biquad_df1_filter_top and biquad_response_check.
`timescale 1ns / 1ps

module testbench;
    import cbq_pkg::*;

    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 40;    // above the 5-section latency
    localparam int IDLE_LIMIT    = 3000;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic signed [CFG_DATA_BITS-1:0] COEF_MAX  = {1'b0, {(CFG_DATA_BITS-1){1'b1}}};
    localparam logic signed [CFG_DATA_BITS-1:0] COEF_MIN  = {1'b1, {(CFG_DATA_BITS-1){1'b0}}};
    localparam logic signed [CFG_DATA_BITS-1:0] COEF_HALF = COEF_ONE >>> 1;
    localparam logic signed [CFG_DATA_BITS-1:0] COEF_NEG_QUARTER = -(COEF_ONE >>> 2);

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

    int mismatch_count;
    int samples_in_flight;
    int random_sent;
    bit sender_calm;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cascaded_biquad_df1_filter_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    biquad_response_check i_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample_in         (sample_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .sample_out        (sample_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .samples_in_flight (samples_in_flight)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 65)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            case ($urandom_range(0, 4))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                3:       return '1;
                default: return SAMPLE_BITS'(1);
            endcase
        end
        else if (roll < 25)
            return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
        else
            return SAMPLE_BITS'($urandom);
    endfunction

    // span: magnitude bound of tame values, in units of 1.0
    function automatic logic [CFG_DATA_BITS-1:0] pick_coef(input int span);
        int roll;
        int lim;
        roll = $urandom_range(0, 99);
        lim  = span <<< COEF_FRAC;
        if (roll < 60)
            return int'($urandom_range(0, 2 * lim)) - lim;
        else if (roll < 85)
            return $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0:       return COEF_MAX;
                1:       return COEF_MIN;
                2:       return '0;
                default: return COEF_ONE;
            endcase
        end
    endfunction

    // Leaves in_valid high after the transfer so back-to-back samples need one assignment.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    task automatic drain_filter();
        in_valid <= 1'b0;
        @(posedge clk);
        while (samples_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_random();
        logic [CFG_DATA_BITS-1:0] noise;
        noise = $urandom;
        write_reg(REG_BYPASS, {noise[CFG_DATA_BITS-1:1], ($urandom_range(0, 9) == 0)});
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_COEF_B0, pick_coef(1));
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_COEF_B1, pick_coef(2));
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_COEF_B2, pick_coef(1));
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_COEF_A1, pick_coef(2));
        if ($urandom_range(0, 9) < 7)
            write_reg(REG_COEF_A2, pick_coef(1));
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_UNMAPPED, $urandom);
        // skipping the count write keeps the delay lines across phases
        if ($urandom_range(0, 9) < 8)
        begin
            noise = $urandom;
            write_reg(REG_STAGE_COUNT,
                      {noise[CFG_DATA_BITS-1:STAGE_CNT_BITS],
                       STAGE_CNT_BITS'($urandom_range(0, 7))});
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: mostly ready, short and long stalls, calm stretches, and a
    // long hold-off now and then so the filter backs up into its input.
    initial
    begin
        int outputs_taken;
        int next_hold_mark;
        int stall_left;
        int calm_left;
        int roll;
        outputs_taken  = 0;
        next_hold_mark = 50;
        stall_left     = 0;
        calm_left      = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                outputs_taken++;
            if (outputs_taken >= next_hold_mark)
            begin
                next_hold_mark += 450;
                stall_left = 400;
                calm_left  = 0;
            end
            if (stall_left == 0 && calm_left == 0 && $urandom_range(0, 199) == 0)
                calm_left = $urandom_range(100, 300);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready  <= 1'b0;
                    stall_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(15, 80);
                end
            end
        end
    end

    // Watchdog: any cycle without a transfer on any channel counts as idle.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("cascaded_biquad_df1_filter_top regression: fail");
        $finish;
    end

    initial
    begin
        int burst;
        random_sent = 0;
        sender_calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two sections of unity gain pass samples through
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        send_sample(SAMPLE_BITS'(1));
        drain_filter();

        // bypass wins over a full cascade and a huge gain
        write_reg(REG_BYPASS, '1);
        write_reg(REG_STAGE_COUNT, 5);
        write_reg(REG_COEF_B0, COEF_MAX);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_BITS'(12345));
        send_sample(SAMPLE_MIN);
        drain_filter();

        // one section, max positive gain: saturates both ways
        write_reg(REG_BYPASS, {{(CFG_DATA_BITS-1){1'b1}}, 1'b0});
        write_reg(REG_STAGE_COUNT, 1);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_BITS'(1));
        drain_filter();

        // most negative gain
        write_reg(REG_COEF_B0, COEF_MIN);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        drain_filter();

        // half gain: ties round toward plus infinity
        write_reg(REG_COEF_B0, COEF_HALF);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_BITS'(1));
        send_sample('1);
        send_sample(SAMPLE_BITS'(3));
        send_sample(SAMPLE_BITS'(-3));
        drain_filter();

        // zero sections pass through; an unmapped index changes nothing
        write_reg(REG_STAGE_COUNT, '0);
        write_reg(REG_UNMAPPED, '1);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_BITS'(777));
        drain_filter();

        // count above the section limit, extreme feedback, impulse response
        write_reg(REG_STAGE_COUNT, '1);
        write_reg(REG_COEF_B0, COEF_ONE);
        write_reg(REG_COEF_B1, COEF_MAX);
        write_reg(REG_COEF_B2, COEF_NEG_QUARTER);
        write_reg(REG_COEF_A1, COEF_MIN);
        write_reg(REG_COEF_A2, COEF_MAX);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample('0);
        send_sample('0);
        drain_filter();

        while (random_sent < RANDOM_ITEMS)
        begin
            configure_random();
            sender_calm = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(30, 60);
            repeat (burst)
            begin
                send_sample(pick_sample());
                random_sent++;
            end
            drain_filter();
        end

        if (mismatch_count == 0 && samples_in_flight == 0)
            $display("cascaded_biquad_df1_filter_top regression: pass");
        else
            $display("cascaded_biquad_df1_filter_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cbq_pkg.sv
design/cbq_mac.sv
design/cascaded_biquad_df1_filter_top.sv
tb/sv/biquad_response_check.sv
tb/sv/testbench.sv
